// ----- rtl/sit_pkg.sv -----
// Shared types and constants for the segment intersection test.
`default_nettype none
package sit_pkg;
   localparam int COORD_BITS = 32;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int BOUND_BITS = COORD_BITS + 3;
   localparam int LEN_BITS   = 32;
   localparam int TOL_BITS   = 16;
   localparam int NUM_BOUNDS = 8;

   typedef enum logic [1:0] {
      CSR_MIN_LEN_SQ   = 2'd0,
      CSR_PARALLEL_TOL = 2'd1,
      CSR_COORD_TOL    = 2'd2
   } csr_index_type;

   // bound order: a.x lo/hi, a.y lo/hi, b.x lo/hi, b.y lo/hi
   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax0;
      logic signed [COORD_BITS-1:0] ay0;
      logic signed [COORD_BITS-1:0] bx0;
      logic signed [COORD_BITS-1:0] by0;
      logic signed [DELTA_BITS-1:0] dxa;
      logic signed [DELTA_BITS-1:0] dya;
      logic signed [DELTA_BITS-1:0] dxb;
      logic signed [DELTA_BITS-1:0] dyb;
      logic [NUM_BOUNDS-1:0][BOUND_BITS-1:0] bound;
   } entry_type;
endpackage
`default_nettype wire

// ----- rtl/segment_intersection_test.sv -----
// Top level of the segment intersection test.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  eight Q16.16 coordinates
//  rsp      out        rsp_valid / rsp_ready  crosses
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One beat per cycle sustained while rsp is not stalled.
// A req beat is written into a queue slot; its pop loads stage 1, and stages 2 to 6 follow in order.
// Reset clears the queue, pipeline valids and csr registers; csr always ready.
// A stalled rsp freezes the pipeline; the two-entry queue takes up to two more req beats.
`default_nettype none
module segment_intersection_test
   import sit_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_crosses,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [LEN_BITS-1:0]          csr_data
);
   logic [LEN_BITS-1:0] min_len_sq_ff, parallel_tol_ff;
   logic [TOL_BITS-1:0] coord_tol_ff;
   entry_type front_entry, queue_entry;
   logic q_valid, q_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_sq_ff   <= '0;
         parallel_tol_ff <= '0;
         coord_tol_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_LEN_SQ:   min_len_sq_ff   <= csr_data;
            CSR_PARALLEL_TOL: parallel_tol_ff <= csr_data;
            CSR_COORD_TOL:    coord_tol_ff    <= csr_data[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   sit_front u_front (
      .ax0(req_seg_a_start_x), .ay0(req_seg_a_start_y),
      .ax1(req_seg_a_end_x),   .ay1(req_seg_a_end_y),
      .bx0(req_seg_b_start_x), .by0(req_seg_b_start_y),
      .bx1(req_seg_b_end_x),   .by1(req_seg_b_end_y),
      .coord_tol(coord_tol_ff),
      .entry(front_entry)
   );

   sit_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(req_valid), .push_ready(req_ready), .push_data(front_entry),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(queue_entry)
   );

   sit_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(queue_entry),
      .min_len_sq(min_len_sq_ff), .parallel_tol(parallel_tol_ff),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_crosses(rsp_crosses)
   );
endmodule
`default_nettype wire

// ----- rtl/sit_front.sv -----
// Front end: deltas and widened bounding boxes of both segments.
`default_nettype none
module sit_front
   import sit_pkg::*;
(
   input  wire logic signed [COORD_BITS-1:0] ax0,
   input  wire logic signed [COORD_BITS-1:0] ay0,
   input  wire logic signed [COORD_BITS-1:0] ax1,
   input  wire logic signed [COORD_BITS-1:0] ay1,
   input  wire logic signed [COORD_BITS-1:0] bx0,
   input  wire logic signed [COORD_BITS-1:0] by0,
   input  wire logic signed [COORD_BITS-1:0] bx1,
   input  wire logic signed [COORD_BITS-1:0] by1,
   input  wire logic [TOL_BITS-1:0]          coord_tol,
   output entry_type                         entry
);
   logic signed [COORD_BITS-1:0] s [4];
   logic signed [COORD_BITS-1:0] e [4];
   logic signed [BOUND_BITS-1:0] tol;
   logic signed [BOUND_BITS-1:0] lo;
   logic signed [BOUND_BITS-1:0] hi;

   assign s[0] = ax0; assign e[0] = ax1;
   assign s[1] = ay0; assign e[1] = ay1;
   assign s[2] = bx0; assign e[2] = bx1;
   assign s[3] = by0; assign e[3] = by1;
   assign tol = $signed({{(BOUND_BITS-TOL_BITS){1'b0}}, coord_tol});

   always_comb begin
      lo = '0;
      hi = '0;
      entry.ax0 = ax0;
      entry.ay0 = ay0;
      entry.bx0 = bx0;
      entry.by0 = by0;
      entry.dxa = DELTA_BITS'(ax1) - DELTA_BITS'(ax0);
      entry.dya = DELTA_BITS'(ay1) - DELTA_BITS'(ay0);
      entry.dxb = DELTA_BITS'(bx1) - DELTA_BITS'(bx0);
      entry.dyb = DELTA_BITS'(by1) - DELTA_BITS'(by0);
      for (int i = 0; i < 4; i++) begin
         if (s[i] > e[i]) begin
            lo = BOUND_BITS'(e[i]);
            hi = BOUND_BITS'(s[i]);
         end else begin
            lo = BOUND_BITS'(s[i]);
            hi = BOUND_BITS'(e[i]);
         end
         entry.bound[2*i]   = lo - tol;
         entry.bound[2*i+1] = hi + tol;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/sit_queue.sv -----
// Two-entry queue between front end and arithmetic pipeline.
`default_nettype none
module sit_queue
   import sit_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire entry_type push_data,
   output logic           pop_valid,
   input  wire logic      pop_ready,
   output entry_type      pop_data
);
   entry_type  mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign wr_in      = wr_ff ^ push;
   assign rd_in      = rd_ff ^ pop;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

// ----- rtl/sit_back.sv -----
// Back end: six-stage exact arithmetic pipeline with output register.
`default_nettype none
module sit_back
   import sit_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire entry_type           in_data,
   input  wire logic [LEN_BITS-1:0] min_len_sq,
   input  wire logic [LEN_BITS-1:0] parallel_tol,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic                     out_crosses
);
   localparam int P1 = 2*DELTA_BITS;       // square / product of deltas
   localparam int L2 = P1 + 1;             // squared length
   localparam int N2 = P1 + 2;             // cross product
   localparam int C2 = P1;                 // line constant
   localparam int HB = C2 - DELTA_BITS;    // high part of line constant
   localparam int MH = HB + DELTA_BITS;
   localparam int ML = DELTA_BITS + 1 + DELTA_BITS;
   localparam int MW = C2 + DELTA_BITS + 1;
   localparam int NL = N2 / 2;
   localparam int BP = 2*BOUND_BITS;
   localparam int PW = BOUND_BITS + N2 + 1;

   logic en;
   logic [6:1] v_ff;

   // stage 1
   logic signed [P1-1:0] dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff, n1_ff, n2_ff;
   logic signed [P1-1:0] c1a_ff, c1b_ff, c2a_ff, c2b_ff;
   logic signed [DELTA_BITS-1:0] dxa1_ff, dya1_ff, dxb1_ff, dyb1_ff;
   logic signed [BOUND_BITS-1:0] bnd1_ff [NUM_BOUNDS];
   // stage 2
   logic signed [L2-1:0] lena_ff, lenb_ff;
   logic signed [N2-1:0] n_ff;
   logic signed [C2-1:0] c1_ff, c2_ff;
   logic signed [DELTA_BITS-1:0] dxa2c_ff, dya2c_ff, dxb2c_ff, dyb2c_ff;
   logic signed [BOUND_BITS-1:0] bnd2_ff [NUM_BOUNDS];
   // stage 3
   logic deg3_ff, neg3_ff;
   logic [N2-1:0] nabs3_ff;
   logic signed [MH-1:0] mh1_ff, mh2_ff, kh1_ff, kh2_ff;
   logic signed [ML-1:0] ml1_ff, ml2_ff, kl1_ff, kl2_ff;
   logic signed [BOUND_BITS-1:0] bnd3_ff [NUM_BOUNDS];
   // stage 4
   logic deg4_ff, neg4_ff, par4_ff;
   logic signed [MW-1:0] m4_ff, k4_ff;
   logic signed [BP-1:0] bl4_ff [NUM_BOUNDS];
   logic signed [BP-1:0] bh4_ff [NUM_BOUNDS];
   // stage 5
   logic rej5_ff;
   logic signed [PW-1:0] m5_ff, k5_ff;
   logic signed [PW-1:0] prod5_ff [NUM_BOUNDS];
   // stage 6
   logic cross6_ff, cross6_in;

   logic signed [HB-1:0] c1h, c2h;
   logic signed [DELTA_BITS:0] c1l, c2l;
   logic signed [BOUND_BITS-1:0] nl, nh;
   logic signed [PW-1:0] mcmp, kcmp;

   assign en        = !v_ff[6] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[6];
   assign out_crosses = cross6_ff;

   assign c1h = c1_ff[C2-1:DELTA_BITS];
   assign c2h = c2_ff[C2-1:DELTA_BITS];
   assign c1l = $signed({1'b0, c1_ff[DELTA_BITS-1:0]});
   assign c2l = $signed({1'b0, c2_ff[DELTA_BITS-1:0]});
   assign nl  = $signed({{(BOUND_BITS-NL){1'b0}}, nabs3_ff[NL-1:0]});
   assign nh  = $signed({{(BOUND_BITS-NL){1'b0}}, nabs3_ff[N2-1:NL]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:1], in_valid};
      end
   end

   always_comb begin
      mcmp = m5_ff;
      kcmp = k5_ff;
      cross6_in = !rej5_ff
         && mcmp >= prod5_ff[0] && mcmp <= prod5_ff[1]
         && kcmp >= prod5_ff[2] && kcmp <= prod5_ff[3]
         && mcmp >= prod5_ff[4] && mcmp <= prod5_ff[5]
         && kcmp >= prod5_ff[6] && kcmp <= prod5_ff[7];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // stage 1: products of deltas and coordinates
         dxa2_ff <= P1'(in_data.dxa) * P1'(in_data.dxa);
         dya2_ff <= P1'(in_data.dya) * P1'(in_data.dya);
         dxb2_ff <= P1'(in_data.dxb) * P1'(in_data.dxb);
         dyb2_ff <= P1'(in_data.dyb) * P1'(in_data.dyb);
         n1_ff   <= P1'(in_data.dxa) * P1'(in_data.dyb);
         n2_ff   <= P1'(in_data.dya) * P1'(in_data.dxb);
         c1a_ff  <= P1'(in_data.ax0) * P1'(in_data.dya);
         c1b_ff  <= P1'(in_data.ay0) * P1'(in_data.dxa);
         c2a_ff  <= P1'(in_data.bx0) * P1'(in_data.dyb);
         c2b_ff  <= P1'(in_data.by0) * P1'(in_data.dxb);
         dxa1_ff <= in_data.dxa;
         dya1_ff <= in_data.dya;
         dxb1_ff <= in_data.dxb;
         dyb1_ff <= in_data.dyb;
         for (int i = 0; i < NUM_BOUNDS; i++) bnd1_ff[i] <= $signed(in_data.bound[i]);
         // stage 2: lengths, cross product, line constants
         lena_ff  <= L2'(dxa2_ff) + L2'(dya2_ff);
         lenb_ff  <= L2'(dxb2_ff) + L2'(dyb2_ff);
         n_ff     <= N2'(n1_ff) - N2'(n2_ff);
         c1_ff    <= c1a_ff - c1b_ff;
         c2_ff    <= c2a_ff - c2b_ff;
         dxa2c_ff <= dxa1_ff;
         dya2c_ff <= dya1_ff;
         dxb2c_ff <= dxb1_ff;
         dyb2c_ff <= dyb1_ff;
         for (int i = 0; i < NUM_BOUNDS; i++) bnd2_ff[i] <= bnd1_ff[i];
         // stage 3: degenerate check, |n|, split products for m and k
         deg3_ff  <= (lena_ff <= $signed({{(L2-LEN_BITS){1'b0}}, min_len_sq}))
                  || (lenb_ff <= $signed({{(L2-LEN_BITS){1'b0}}, min_len_sq}));
         neg3_ff  <= n_ff[N2-1];
         nabs3_ff <= n_ff[N2-1] ? N2'(-n_ff) : N2'(n_ff);
         mh1_ff   <= MH'(c2h) * MH'(dxa2c_ff);
         mh2_ff   <= MH'(c1h) * MH'(dxb2c_ff);
         kh1_ff   <= MH'(c2h) * MH'(dya2c_ff);
         kh2_ff   <= MH'(c1h) * MH'(dyb2c_ff);
         ml1_ff   <= ML'(c2l) * ML'(dxa2c_ff);
         ml2_ff   <= ML'(c1l) * ML'(dxb2c_ff);
         kl1_ff   <= ML'(c2l) * ML'(dya2c_ff);
         kl2_ff   <= ML'(c1l) * ML'(dyb2c_ff);
         for (int i = 0; i < NUM_BOUNDS; i++) bnd3_ff[i] <= bnd2_ff[i];
         // stage 4: assemble m and k, parallel check, split box products
         deg4_ff <= deg3_ff;
         neg4_ff <= neg3_ff;
         par4_ff <= nabs3_ff <= {{(N2-LEN_BITS){1'b0}}, parallel_tol};
         m4_ff   <= ((MW'(mh1_ff) - MW'(mh2_ff)) <<< DELTA_BITS)
                  + MW'(ml1_ff) - MW'(ml2_ff);
         k4_ff   <= ((MW'(kh1_ff) - MW'(kh2_ff)) <<< DELTA_BITS)
                  + MW'(kl1_ff) - MW'(kl2_ff);
         for (int i = 0; i < NUM_BOUNDS; i++) begin
            bl4_ff[i] <= BP'(bnd3_ff[i]) * BP'(nl);
            bh4_ff[i] <= BP'(bnd3_ff[i]) * BP'(nh);
         end
         // stage 5: sign fix and full box products
         rej5_ff <= deg4_ff || par4_ff;
         m5_ff   <= neg4_ff ? -PW'(m4_ff) : PW'(m4_ff);
         k5_ff   <= neg4_ff ? -PW'(k4_ff) : PW'(k4_ff);
         for (int i = 0; i < NUM_BOUNDS; i++)
            prod5_ff[i] <= (PW'(bh4_ff[i]) <<< NL) + PW'(bl4_ff[i]);
         // stage 6: box compares
         cross6_ff <= cross6_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/sit_checker.sv -----
// Port-level checks for the segment intersection test, bound to the top.
`default_nettype none
module sit_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_crosses,
   input wire logic csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crosses))
      else $error("rsp beat dropped or changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_no_early_rsp: assert property (@(posedge clock)
      reset ##1 !reset |-> !rsp_valid)
      else $error("rsp beat too soon after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> req_ready && csr_ready)
      else $error("channels not open after reset");
endmodule

bind segment_intersection_test sit_checker u_sit_checker (
   .clock(clock), .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_crosses(rsp_crosses),
   .csr_ready(csr_ready)
);
`default_nettype wire

// ----- tb/tb_segment_intersection_test.sv -----
// Self-checking testbench for the segment intersection test block.
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_intersection_test;
   import sit_pkg::*;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef struct {
      coord_type ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   } seg_pair_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_seg_a_start_x = '0, req_seg_a_start_y = '0;
   coord_type req_seg_a_end_x = '0, req_seg_a_end_y = '0;
   coord_type req_seg_b_start_x = '0, req_seg_b_start_y = '0;
   coord_type req_seg_b_end_x = '0, req_seg_b_end_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_crosses;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_MIN_LEN_SQ;
   logic [LEN_BITS-1:0] csr_data = '0;
   logic req_ready_seen = 1'b0;
   logic req_beat;

   segment_intersection_test dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_seg_a_start_x(req_seg_a_start_x), .req_seg_a_start_y(req_seg_a_start_y),
      .req_seg_a_end_x(req_seg_a_end_x), .req_seg_a_end_y(req_seg_a_end_y),
      .req_seg_b_start_x(req_seg_b_start_x), .req_seg_b_start_y(req_seg_b_start_y),
      .req_seg_b_end_x(req_seg_b_end_x), .req_seg_b_end_y(req_seg_b_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_crosses(rsp_crosses),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register shadow
   logic [31:0] min_len_sq;
   logic [31:0] parallel_tol;
   logic [15:0] coord_tol;

   seg_pair_type pending_pairs[$];
   logic      expected_crosses[$];
   logic      stim_done = 1'b0;
   logic      hold_req = 1'b0;
   int        mismatches = 0;
   int        idle_cycles = 0;
   int        req_gap = 0;
   int        rsp_gap = 0;

   // bounds check: lo*den <= num <= hi*den
   function automatic bit within_box(logic signed [199:0] num, logic signed [199:0] den,
                                     coord_type s, coord_type e, logic [15:0] tol);
      logic signed [199:0] lo, hi;
      lo = (s > e) ? e : s;
      hi = (s > e) ? s : e;
      lo = lo - $signed({184'd0, tol});
      hi = hi + $signed({184'd0, tol});
      return (num >= lo * den) && (hi * den >= num);
   endfunction

   function automatic logic predict_crosses(seg_pair_type p);
      logic signed [199:0] dxa, dya, dxb, dyb, n, c1, c2, m, k;
      logic signed [199:0] lim, ptol;
      dxa = $signed(p.ax1) - $signed(p.ax0);
      dya = $signed(p.ay1) - $signed(p.ay0);
      dxb = $signed(p.bx1) - $signed(p.bx0);
      dyb = $signed(p.by1) - $signed(p.by0);
      lim = $signed({168'd0, min_len_sq});
      ptol = $signed({168'd0, parallel_tol});
      if (dxa * dxa + dya * dya <= lim) return 1'b0;
      if (dxb * dxb + dyb * dyb <= lim) return 1'b0;
      n = dxa * dyb - dya * dxb;
      if (n <= ptol && n >= -ptol) return 1'b0;
      c1 = p.ax0 * dya - p.ay0 * dxa;
      c2 = p.bx0 * dyb - p.by0 * dxb;
      m = c2 * dxa - dxb * c1;
      k = c2 * dya - c1 * dyb;
      if (n < 0) begin
         n = -n; m = -m; k = -k;
      end
      return within_box(m, n, p.ax0, p.ax1, coord_tol) &&
             within_box(k, n, p.ay0, p.ay1, coord_tol) &&
             within_box(m, n, p.bx0, p.bx1, coord_tol) &&
             within_box(k, n, p.by0, p.by1, coord_tol);
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 5))
         0: return $signed($urandom());
         1: return coord_type'(32'sh8000_0000);
         2: return coord_type'(32'sh7fff_ffff);
         default: return coord_type'($signed($urandom_range(0, 32'h0014_0000)) - 32'sh000a_0000);
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // queue a pair; prediction uses the registers current at queue time
   task automatic push_pair(seg_pair_type p);
      pending_pairs.push_back(p);
      expected_crosses.push_back(predict_crosses(p));
   endtask

   task automatic make_pair(coord_type ax0, coord_type ay0, coord_type ax1, coord_type ay1,
                            coord_type bx0, coord_type by0, coord_type bx1, coord_type by1);
      seg_pair_type p;
      p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
      p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
      push_pair(p);
   endtask

   task automatic wait_idle();
      while (pending_pairs.size() != 0 || expected_crosses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // registers change only with nothing in flight
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MIN_LEN_SQ:   min_len_sq   = value;
         CSR_PARALLEL_TOL: parallel_tol = value;
         CSR_COORD_TOL:    coord_tol    = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count);
      seg_pair_type p;
      int kind;
      int t;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            // near-crossing pair around a random center; kind 5 makes b parallel to a
            t = $urandom_range(1, 32'h0004_0000);
            p.ax0 = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            p.ay0 = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            p.ax1 = p.ax0 + $signed($urandom_range(0, 2 * t)) - t;
            p.ay1 = p.ay0 + $signed($urandom_range(0, 2 * t)) - t;
            p.bx0 = p.ax0 + $signed($urandom_range(0, 2 * t)) - t;
            p.by0 = p.ay1 + $signed($urandom_range(0, 2 * t)) - t;
            p.bx1 = p.ax1 + $signed($urandom_range(0, 2 * t)) - t;
            p.by1 = p.ay0 + $signed($urandom_range(0, 2 * t)) - t;
            if (kind == 5) begin
               p.bx1 = p.bx0 + (p.ax1 - p.ax0);
               p.by1 = p.by0 + (p.ay1 - p.ay0);
            end
         end else begin
            p.ax0 = rand_coord(); p.ay0 = rand_coord();
            p.ax1 = rand_coord(); p.ay1 = rand_coord();
            p.bx0 = rand_coord(); p.by0 = rand_coord();
            p.bx1 = rand_coord(); p.by1 = rand_coord();
         end
         push_pair(p);
      end
      wait_idle();
   endtask

   // stimulus
   initial begin
      min_len_sq = '0; parallel_tol = '0; coord_tol = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // proper crossing, touching ends, T junction
      make_pair(0, 0, 32'sh20000, 32'sh20000, 0, 32'sh20000, 32'sh20000, 0);
      make_pair(0, 0, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 32'sh10000);
      make_pair(0, 0, 32'sh20000, 0, 32'sh10000, 32'sh10000, 32'sh10000, 0);
      // just missing, degenerate, parallel, collinear overlap
      make_pair(0, 0, 32'sh10000, 0, 32'sh10001, 32'sh10000, 32'sh10001, -32'sh10000);
      make_pair(5, 5, 5, 5, 0, 0, 32'sh10000, 32'sh10000);
      make_pair(0, 0, 32'sh10000, 0, 0, 1, 32'sh10000, 1);
      make_pair(0, 0, 32'sh20000, 0, 32'sh10000, 0, 32'sh30000, 0);
      // extremes, then a small crossing around the origin
      make_pair(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
      make_pair(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
      make_pair(-1, -1, 1, 1, -1, 1, 1, -1);
      wait_idle();

      // tolerances: widened box catches a near miss, length and parallel limits
      write_reg(CSR_COORD_TOL, 32'h0000_0001);
      make_pair(0, 0, 32'sh10000, 0, 32'sh10001, 32'sh10000, 32'sh10001, -32'sh10000);
      make_pair(0, 0, 32'sh10000, 0, 32'sh10002, 32'sh10000, 32'sh10002, -32'sh10000);
      write_reg(CSR_MIN_LEN_SQ, 32'h0000_0002);
      make_pair(0, 0, 1, 1, 0, 1, 1, 0);
      make_pair(0, 0, 2, 2, 0, 2, 2, 0);
      write_reg(CSR_PARALLEL_TOL, 32'h0000_0008);
      make_pair(0, 0, 2, 2, 0, 2, 2, 0);
      make_pair(0, 0, 3, 3, 0, 3, 3, 0);
      wait_idle();

      write_reg(CSR_MIN_LEN_SQ, '0);
      write_reg(CSR_PARALLEL_TOL, '0);
      write_reg(CSR_COORD_TOL, '0);
      random_phase(250);

      // pause the sender mid-stream until every result has drained
      fork
         random_phase(40);
         begin
            do @(posedge clock); while (pending_pairs.size() > 20);
            hold_req = 1'b1;
            while (expected_crosses.size() != pending_pairs.size()) @(posedge clock);
            hold_req = 1'b0;
         end
      join

      write_reg(CSR_MIN_LEN_SQ, 32'hffff_ffff);
      write_reg(CSR_PARALLEL_TOL, 32'hffff_ffff);
      write_reg(CSR_COORD_TOL, 32'h0000_ffff);
      random_phase(150);

      write_reg(CSR_MIN_LEN_SQ, $urandom_range(0, 32'h0100_0000));
      write_reg(CSR_PARALLEL_TOL, $urandom_range(0, 32'h1000_0000));
      write_reg(CSR_COORD_TOL, $urandom_range(0, 32'h0000_ffff));
      random_phase(200);

      write_reg(CSR_MIN_LEN_SQ, $urandom());
      write_reg(CSR_PARALLEL_TOL, $urandom());
      write_reg(CSR_COORD_TOL, $urandom_range(0, 32'h0000_ffff));
      random_phase(210);

      stim_done = 1'b1;
   end

   // driver
   assign req_beat = req_valid && req_ready;

   always @(posedge clock) begin
      req_ready_seen <= req_beat;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_ready_seen) begin
         // hold until accepted
      end else begin
         if (req_ready_seen) void'(pending_pairs.pop_front());
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_pairs.size() > (req_ready_seen ? 0 : 0) && !hold_req) begin
            req_valid         <= 1'b1;
            req_seg_a_start_x <= pending_pairs[0].ax0;
            req_seg_a_start_y <= pending_pairs[0].ay0;
            req_seg_a_end_x   <= pending_pairs[0].ax1;
            req_seg_a_end_y   <= pending_pairs[0].ay1;
            req_seg_b_start_x <= pending_pairs[0].bx0;
            req_seg_b_start_y <= pending_pairs[0].by0;
            req_seg_b_end_x   <= pending_pairs[0].bx1;
            req_seg_b_end_y   <= pending_pairs[0].by1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_crosses.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected rsp beat: crosses=%0b", rsp_crosses);
         end else if (rsp_crosses !== expected_crosses[0]) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("crosses mismatch: expected %0b actual %0b",
                        expected_crosses[0], rsp_crosses);
            void'(expected_crosses.pop_front());
         end else begin
            void'(expected_crosses.pop_front());
         end
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if (req_beat || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || (hold_req && pending_pairs.size() == 0) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait_idle();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
